// ----- design/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the pulse period power meter
// Configuration record, register indexes, reset values, sequencer codes.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int unsigned TIMER_BITS_DEF = 24;
    localparam int unsigned WATTS_BITS_DEF = 20;
    localparam int unsigned DVW_DEF        = 24;

    localparam int unsigned CFG_W      = 20;
    localparam int unsigned TO_W       = 24;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned FRAC_W     = 21;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned DIV_N      = 22;

    localparam logic [CFG_IDX_W-1:0] REG_WATTS_CONSTANT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_INCREMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_UNIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LF_THRESHOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TIMEOUT     = 3'd4;

    localparam logic [CFG_W-1:0] WATTS_CONSTANT_RST   = 20'd972000;
    localparam logic [CFG_W-1:0] ENERGY_INCREMENT_RST = 20'd432000;
    localparam logic [CFG_W-1:0] ENERGY_UNIT_RST      = 20'd100000;
    localparam logic [CFG_W-1:0] LF_THRESHOLD_RST     = 20'd500;
    localparam logic [TO_W-1:0]  ZERO_TIMEOUT_RST     = 24'd90000;

    typedef struct packed {
        logic [CFG_W-1:0] watts_constant;
        logic [CFG_W-1:0] energy_increment;
        logic [CFG_W-1:0] energy_unit;
        logic [CFG_W-1:0] lf_select_threshold;
        logic [TO_W-1:0]  zero_timeout_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        JOB_HF,
        JOB_LF,
        JOB_CARRY,
        JOB_DECAY
    } job_t;

endpackage

// ----- design/pulse_period_power_meter.sv -----
// ----------------------------------------------------------------------------
// pulse_period_power_meter: power and energy from meter pulse pins
// One input transfer per millisecond tick carries the levels of the active-low
// hf_pin, lf0_pin and lf1_pin. Each transfer yields exactly one result transfer
// with watts, energy_wh, hf_led and lf_led. Setup registers are written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no item is in
// flight, as the block does not enforce it. Each division performed adds to
// the time from input transfer to result. Up to three divisions per item
// (HF watts, LF watts, energy carry) go one after another through a single
// divider retiring two quotient bits a cycle; the idle decay division only
// runs on ticks with no edge and so always stands alone.
// in_stall is high from the input transfer until the result is registered;
// the next item can then be taken while the result waits.
// Reset: setup registers return to their defaults, counters, estimates and
// energy clear, no result pending. A stalled result holds its value; the item
// behind it finishes its work and waits until the output register frees.
// ----------------------------------------------------------------------------
module pulse_period_power_meter #(
    parameter int unsigned TIMER_BITS = ppm_pkg::TIMER_BITS_DEF,
    parameter int unsigned WATTS_BITS = ppm_pkg::WATTS_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             hf_pin,
    input  logic                             lf0_pin,
    input  logic                             lf1_pin,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ppm_pkg::CFG_W-1:0]        watts,
    output logic [ppm_pkg::TOTAL_W-1:0]      energy_wh,
    output logic                             hf_led,
    output logic                             lf_led
);
    import ppm_pkg::*;

    localparam int unsigned DVW  = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int unsigned CMPW = (TIMER_BITS > TO_W) ? TIMER_BITS : TO_W;
    localparam int unsigned WCW  = (WATTS_BITS > DIV_N) ? WATTS_BITS : DIV_N;
    localparam int unsigned THW  = (WATTS_BITS > CFG_W) ? WATTS_BITS : CFG_W;

    function automatic logic [WATTS_BITS-1:0] clamp_w(input logic [DIV_N-1:0] q);
        logic [WCW-1:0] qx;
        begin
            qx = WCW'(q);
            clamp_w = (|(qx >> WATTS_BITS)) ? '1 : qx[WATTS_BITS-1:0];
        end
    endfunction

    function automatic logic [TIMER_BITS-1:0] tick(input logic [TIMER_BITS-1:0] c);
        tick = (&c) ? c : c + 1'b1;
    endfunction

    function automatic job_t next_job(input job_t j);
        unique case (j)
            JOB_HF:    next_job = JOB_LF;
            JOB_LF:    next_job = JOB_CARRY;
            JOB_CARRY: next_job = JOB_DECAY;
            default:   next_job = JOB_DECAY;
        endcase
    endfunction

    cfg_t cfg;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [TIMER_BITS-1:0] hf_el_reg;
    logic [TIMER_BITS-1:0] lf_el_reg;
    logic [TIMER_BITS-1:0] idle_reg;
    logic                  hf_seen_reg;
    logic                  lf_seen_reg;
    logic [WATTS_BITS-1:0] hf_power_reg;
    logic [WATTS_BITS-1:0] lf_power_reg;
    logic [TIMER_BITS-1:0] last_hf_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic                  hf_tog_reg;
    logic                  lf_tog_reg;
    logic                  hf_edge_reg;
    logic                  lf_edge_reg;
    logic [TIMER_BITS-1:0] lf_period_reg;
    logic [DIV_N-1:0]      sum_reg;
    logic [WATTS_BITS-1:0] decay_w_reg;

    logic                  out_valid_reg;
    logic [CFG_W-1:0]      watts_reg;
    logic [TOTAL_W-1:0]    energy_reg;
    logic                  hf_led_reg;
    logic                  lf_led_reg;

    logic                  accept;
    logic                  hf_act;
    logic                  lf_act;
    logic                  hf_edge;
    logic                  lf_edge;
    logic [TIMER_BITS-1:0] hf_tick;
    logic [TIMER_BITS-1:0] lf_tick;
    logic [TIMER_BITS-1:0] idle_tick;
    logic [CFG_W-1:0]      unit_eff;
    logic                  carry_need;
    logic                  zero_show;
    logic                  decay_need;
    logic                  job_need;
    logic                  out_free;
    logic                  load_out;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [DIV_N-1:0]      div_dividend;
    logic [DVW-1:0]        div_divisor;
    logic [DIV_N-1:0]      div_quo;
    logic [DVW-1:0]        div_rem;
    logic [WATTS_BITS-1:0] sel_w;
    logic [WATTS_BITS-1:0] shown_w;
    logic [THW-1:0]        shown_x;

    ppm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppm_div #(
        .DVW (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        hf_act    = !hf_pin;
        lf_act    = !lf0_pin || !lf1_pin;
        hf_edge   = hf_act && !hf_seen_reg;
        lf_edge   = lf_act && !lf_seen_reg;
        hf_tick   = tick(hf_el_reg);
        lf_tick   = tick(lf_el_reg);
        idle_tick = tick(idle_reg);

        unit_eff   = (cfg.energy_unit == '0) ? CFG_W'(1) : cfg.energy_unit;
        carry_need = lf_edge_reg && (sum_reg > DIV_N'(unit_eff));
        zero_show  = (CMPW'(idle_reg) > CMPW'(cfg.zero_timeout_ms)) || (last_hf_reg == '0);
        decay_need = !zero_show && (idle_reg > last_hf_reg);

        case (job_reg)
            JOB_HF:    job_need = hf_edge_reg && (last_hf_reg != '0);
            JOB_LF:    job_need = lf_edge_reg && (lf_period_reg != '0);
            JOB_CARRY: job_need = carry_need;
            default:   job_need = decay_need;
        endcase

        case (job_reg)
            JOB_HF:
            begin
                div_dividend = DIV_N'(cfg.watts_constant);
                div_divisor  = DVW'(last_hf_reg);
            end
            JOB_LF:
            begin
                div_dividend = DIV_N'(cfg.watts_constant);
                div_divisor  = DVW'(lf_period_reg);
            end
            JOB_CARRY:
            begin
                div_dividend = sum_reg - 1'b1;
                div_divisor  = DVW'(unit_eff);
            end
            default:
            begin
                div_dividend = DIV_N'(cfg.watts_constant);
                div_divisor  = DVW'(idle_reg);
            end
        endcase

        sel_w   = (THW'(lf_power_reg) > THW'(cfg.lf_select_threshold)) ? lf_power_reg
                                                                       : hf_power_reg;
        shown_w = zero_show ? '0 : (decay_need ? decay_w_reg : sel_w);
        shown_x = THW'(shown_w);
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PICK;
                    job_next   = JOB_HF;
                end
            end
            ST_PICK:
            begin
                if (job_need)
                    state_next = ST_WAIT;
                else if (job_reg == JOB_DECAY)
                    state_next = ST_FINISH;
                else
                    job_next = next_job(job_reg);
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (job_reg == JOB_DECAY)
                        state_next = ST_FINISH;
                    else
                    begin
                        state_next = ST_PICK;
                        job_next   = next_job(job_reg);
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        accept    = in_valid && (state_reg == ST_IDLE);
        div_start = (state_reg == ST_PICK) && job_need;
        out_free  = !out_valid_reg || !out_stall;
        load_out  = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_HF;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_el_reg     <= '0;
            lf_el_reg     <= '0;
            idle_reg      <= '0;
            hf_seen_reg   <= 1'b0;
            lf_seen_reg   <= 1'b0;
            hf_power_reg  <= '0;
            lf_power_reg  <= '0;
            last_hf_reg   <= '0;
            frac_reg      <= '0;
            total_reg     <= '0;
            hf_tog_reg    <= 1'b0;
            lf_tog_reg    <= 1'b0;
            hf_edge_reg   <= 1'b0;
            lf_edge_reg   <= 1'b0;
            lf_period_reg <= '0;
            sum_reg       <= '0;
            decay_w_reg   <= '0;
        end
        else if (accept)
        begin
            hf_el_reg   <= hf_edge ? '0 : hf_tick;
            lf_el_reg   <= lf_edge ? '0 : lf_tick;
            idle_reg    <= (hf_edge || lf_edge) ? '0 : idle_tick;
            hf_seen_reg <= hf_act;
            lf_seen_reg <= lf_act;
            hf_edge_reg <= hf_edge;
            lf_edge_reg <= lf_edge;
            if (hf_edge)
            begin
                hf_tog_reg  <= !hf_tog_reg;
                last_hf_reg <= hf_tick;
            end
            if (lf_edge)
                lf_tog_reg <= !lf_tog_reg;
            lf_period_reg <= lf_tick;
            sum_reg       <= DIV_N'(frac_reg) + DIV_N'(cfg.energy_increment);
        end
        else if ((state_reg == ST_PICK) && !job_need)
        begin
            case (job_reg)
                JOB_HF:
                begin
                    if (hf_edge_reg)
                        hf_power_reg <= clamp_w(DIV_N'(cfg.watts_constant));
                end
                JOB_LF:
                begin
                    if (lf_edge_reg)
                        lf_power_reg <= clamp_w(DIV_N'(cfg.watts_constant));
                end
                JOB_CARRY:
                begin
                    if (lf_edge_reg)
                        frac_reg <= sum_reg[FRAC_W-1:0];
                end
                default:
                begin
                    decay_w_reg <= decay_w_reg;
                end
            endcase
        end
        else if ((state_reg == ST_WAIT) && div_done)
        begin
            case (job_reg)
                JOB_HF:    hf_power_reg <= clamp_w(div_quo);
                JOB_LF:    lf_power_reg <= clamp_w(div_quo);
                JOB_CARRY:
                begin
                    total_reg <= total_reg + TOTAL_W'(div_quo);
                    frac_reg  <= FRAC_W'({1'b0, div_rem} + 1'b1);
                end
                default:   decay_w_reg <= clamp_w(div_quo);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            watts_reg  <= shown_x[CFG_W-1:0];
            energy_reg <= total_reg;
            hf_led_reg <= hf_tog_reg;
            lf_led_reg <= lf_tog_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign watts     = watts_reg;
    assign energy_wh = energy_reg;
    assign hf_led    = hf_led_reg;
    assign lf_led    = lf_led_reg;

`ifndef ASSERT_OFF
    a_frac_below_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        !frac_reg[FRAC_W-1])
        else $error("energy fraction reached the top bit");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!div_busy && !div_done))
        else $error("input transfer while a division is in flight");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider result arrived outside the wait state");
`endif

endmodule

// ----- design/ppm_cfg.sv -----
// ----------------------------------------------------------------------------
// ppm_cfg: configuration register file
// Holds the five setup registers, written through a plain indexed port.
// ----------------------------------------------------------------------------
module ppm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppm_pkg::cfg_t                    cfg
);
    import ppm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.watts_constant      <= WATTS_CONSTANT_RST;
            cfg_reg.energy_increment    <= ENERGY_INCREMENT_RST;
            cfg_reg.energy_unit         <= ENERGY_UNIT_RST;
            cfg_reg.lf_select_threshold <= LF_THRESHOLD_RST;
            cfg_reg.zero_timeout_ms     <= ZERO_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WATTS_CONSTANT:   cfg_reg.watts_constant      <= cfg_data[CFG_W-1:0];
                REG_ENERGY_INCREMENT: cfg_reg.energy_increment    <= cfg_data[CFG_W-1:0];
                REG_ENERGY_UNIT:      cfg_reg.energy_unit         <= cfg_data[CFG_W-1:0];
                REG_LF_THRESHOLD:     cfg_reg.lf_select_threshold <= cfg_data[CFG_W-1:0];
                REG_ZERO_TIMEOUT:     cfg_reg.zero_timeout_ms     <= cfg_data[TO_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/ppm_div.sv -----
// ----------------------------------------------------------------------------
// ppm_div: shared restoring divider
// Unsigned division, two quotient bits per cycle, quotient and remainder held.
// ----------------------------------------------------------------------------
module ppm_div #(
    parameter int unsigned DVW = ppm_pkg::DVW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ppm_pkg::DIV_N-1:0]     dividend,
    input  logic [DVW-1:0]                divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ppm_pkg::DIV_N-1:0]     quotient,
    output logic [DVW-1:0]                remainder
);
    import ppm_pkg::*;

    localparam int unsigned STEPS = DIV_N / 2;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [DVW-1:0]   rem_reg;
    logic [DIV_N-1:0] quo_reg;
    logic [DVW-1:0]   dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVW:0]     t1;
    logic [DVW:0]     t2;
    logic [DVW-1:0]   r1;
    logic [DVW-1:0]   r2;
    logic             b1;
    logic             b2;
    logic [DIV_N-1:0] quo_next;

    always_comb
    begin
        t1 = {rem_reg, quo_reg[DIV_N-1]};
        b1 = (t1 >= {1'b0, dsr_reg});
        r1 = b1 ? DVW'(t1 - {1'b0, dsr_reg}) : t1[DVW-1:0];
        t2 = {r1, quo_reg[DIV_N-2]};
        b2 = (t2 >= {1'b0, dsr_reg});
        r2 = b2 ? DVW'(t2 - {1'b0, dsr_reg}) : t2[DVW-1:0];
        quo_next = {quo_reg[DIV_N-3:0], b1, b2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2;
            quo_reg <= quo_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
